>>> hw/rtl/slp_pkg.sv
`default_nettype none

package slp_pkg;

  localparam int unsigned LEN_W   = 7;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned LIT_LEN = 5;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [VAL_W-1:0] MAG_LIMIT = 16'h8000;
  localparam logic [VAL_W-1:0] POS_MAX   = 16'h7FFF;

  typedef enum logic [3:0] {
    ST_LIT1 = 4'd0,
    ST_WS1  = 4'd1,
    ST_SGN1 = 4'd2,
    ST_DIG1 = 4'd3,
    ST_LIT2 = 4'd4,
    ST_WS2  = 4'd5,
    ST_SGN2 = 4'd6,
    ST_DIG2 = 4'd7,
    ST_DONE = 4'd8,
    ST_FAIL = 4'd9
  } stage_t;

  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] hum;
    logic [VAL_W-1:0] temp;
  } line_res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CH_SPACE) || (c >= 8'h09 && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [7:0] lit_char(input logic second, input logic [IDX_W-1:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (idx)
      3'd0:    ch = second ? 8'h74 : 8'h68;
      3'd1:    ch = second ? 8'h65 : 8'h75;
      3'd2:    ch = 8'h6D;
      3'd3:    ch = second ? 8'h70 : 8'h69;
      3'd4:    ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    lit_char = ch;
  endfunction

  function automatic logic [VAL_W-1:0] add_digit(input logic [VAL_W-1:0] acc,
                                                 input logic [7:0] c);
    logic [19:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, c[3:0]};
    if (v > {4'b0, MAG_LIMIT}) begin
      v = {4'b0, MAG_LIMIT};
    end
    add_digit = v[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] finish_num(input logic neg,
                                                  input logic [VAL_W-1:0] acc);
    logic [VAL_W-1:0] m;
    m = acc;
    if (neg) begin
      if (m > MAG_LIMIT) begin
        m = MAG_LIMIT;
      end
      finish_num = '0 - m;
    end else begin
      if (m > POS_MAX) begin
        m = POS_MAX;
      end
      finish_num = m;
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/slp_front.sv
`default_nettype none

module slp_front #(
  parameter int unsigned MAX_LINE = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                byte_take,
  input  wire logic [7:0]          rx_byte,
  output logic                     push,
  output slp_pkg::line_res_t       push_data
);

  localparam logic [slp_pkg::LEN_W-1:0] MAX_LEN = slp_pkg::LEN_W'(MAX_LINE);
  localparam logic [slp_pkg::IDX_W-1:0] LAST_IDX = slp_pkg::IDX_W'(slp_pkg::LIT_LEN - 1);

  slp_pkg::stage_t                  stage_r, stage_nxt;
  logic [slp_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic                             neg_r, neg_nxt;
  logic [slp_pkg::VAL_W-1:0]        acc_r, acc_nxt;
  logic [slp_pkg::VAL_W-1:0]        first_r, first_nxt;
  logic [slp_pkg::LEN_W-1:0]        len_r, len_nxt;

  logic is_lf;
  logic overlong;
  logic dig;
  logic spc;
  logic sgn;
  logic lit_hit;
  logic t_hit;

  assign is_lf    = (rx_byte == slp_pkg::CH_LF);
  assign overlong = (len_r >= MAX_LEN);
  assign dig      = slp_pkg::is_digit(rx_byte);
  assign spc      = slp_pkg::is_space(rx_byte);
  assign sgn      = (rx_byte == slp_pkg::CH_PLUS) || (rx_byte == slp_pkg::CH_MINUS);
  assign lit_hit  = (idx_r <= LAST_IDX) &&
                    (rx_byte == slp_pkg::lit_char(stage_r == slp_pkg::ST_LIT2, idx_r));
  assign t_hit    = (rx_byte == slp_pkg::lit_char(1'b1, '0));

  // next stage
  always_comb begin
    stage_nxt = stage_r;
    if (byte_take) begin
      if (is_lf || overlong) begin
        stage_nxt = slp_pkg::ST_LIT1;
      end else begin
        case (stage_r)
          slp_pkg::ST_LIT1, slp_pkg::ST_LIT2: begin
            if (!lit_hit) begin
              stage_nxt = slp_pkg::ST_FAIL;
            end else if (idx_r == LAST_IDX) begin
              stage_nxt = (stage_r == slp_pkg::ST_LIT1) ? slp_pkg::ST_WS1 : slp_pkg::ST_WS2;
            end
          end
          slp_pkg::ST_WS1, slp_pkg::ST_WS2: begin
            if (sgn) begin
              stage_nxt = (stage_r == slp_pkg::ST_WS1) ? slp_pkg::ST_SGN1 : slp_pkg::ST_SGN2;
            end else if (dig) begin
              stage_nxt = (stage_r == slp_pkg::ST_WS1) ? slp_pkg::ST_DIG1 : slp_pkg::ST_DIG2;
            end else if (!spc) begin
              stage_nxt = slp_pkg::ST_FAIL;
            end
          end
          slp_pkg::ST_SGN1, slp_pkg::ST_SGN2: begin
            if (dig) begin
              stage_nxt = (stage_r == slp_pkg::ST_SGN1) ? slp_pkg::ST_DIG1 : slp_pkg::ST_DIG2;
            end else begin
              stage_nxt = slp_pkg::ST_FAIL;
            end
          end
          slp_pkg::ST_DIG1: begin
            if (!dig) begin
              stage_nxt = t_hit ? slp_pkg::ST_LIT2 : slp_pkg::ST_FAIL;
            end
          end
          slp_pkg::ST_DIG2: begin
            if (!dig) begin
              stage_nxt = slp_pkg::ST_DONE;
            end
          end
          slp_pkg::ST_DONE: stage_nxt = slp_pkg::ST_DONE;
          default:          stage_nxt = slp_pkg::ST_FAIL;
        endcase
      end
    end
  end

  // datapath and line result
  always_comb begin
    idx_nxt   = idx_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    first_nxt = first_r;
    len_nxt   = len_r;
    push      = 1'b0;
    push_data.ok   = (stage_r == slp_pkg::ST_DIG2) || (stage_r == slp_pkg::ST_DONE);
    push_data.hum  = first_r;
    push_data.temp = slp_pkg::finish_num(neg_r, acc_r);
    if (byte_take) begin
      if (is_lf || overlong) begin
        push      = is_lf;
        idx_nxt   = '0;
        neg_nxt   = 1'b0;
        acc_nxt   = '0;
        first_nxt = '0;
        len_nxt   = '0;
      end else begin
        len_nxt = len_r + 1'b1;
        case (stage_r)
          slp_pkg::ST_LIT1, slp_pkg::ST_LIT2: begin
            if (lit_hit) begin
              idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
            end
          end
          slp_pkg::ST_WS1, slp_pkg::ST_WS2: begin
            if (!spc) begin
              neg_nxt = (rx_byte == slp_pkg::CH_MINUS);
              acc_nxt = dig ? slp_pkg::add_digit('0, rx_byte) : '0;
            end
          end
          slp_pkg::ST_SGN1, slp_pkg::ST_SGN2, slp_pkg::ST_DIG2: begin
            if (dig) begin
              acc_nxt = slp_pkg::add_digit(acc_r, rx_byte);
            end
          end
          slp_pkg::ST_DIG1: begin
            if (dig) begin
              acc_nxt = slp_pkg::add_digit(acc_r, rx_byte);
            end else begin
              first_nxt = slp_pkg::finish_num(neg_r, acc_r);
              idx_nxt   = t_hit ? slp_pkg::IDX_W'(1) : '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= slp_pkg::ST_LIT1;
      idx_r   <= '0;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      first_r <= '0;
      len_r   <= '0;
    end else begin
      stage_r <= stage_nxt;
      idx_r   <= idx_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
      first_r <= first_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/slp_queue.sv
`default_nettype none

module slp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire slp_pkg::line_res_t push_data,
  input  wire logic               pop,
  output slp_pkg::line_res_t      pop_data,
  output slp_pkg::q_status_t      status
);

  slp_pkg::line_res_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign status.full  = (cnt_r == 2'd2);
  assign status.empty = (cnt_r == 2'd0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/slp_back.sv
`default_nettype none

module slp_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire slp_pkg::q_status_t        q_status,
  input  wire slp_pkg::line_res_t        q_data,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_line_ok,
  output logic                           out_have_valid,
  output logic signed [slp_pkg::VAL_W-1:0] out_humidity,
  output logic signed [slp_pkg::VAL_W-1:0] out_temperature
);

  logic                       valid_r, valid_nxt;
  logic                       seen_r, seen_nxt;
  logic [slp_pkg::VAL_W-1:0]  held_hum_r, held_hum_nxt;
  logic [slp_pkg::VAL_W-1:0]  held_temp_r, held_temp_nxt;
  logic                       ok_r, ok_nxt;
  logic                       hv_r, hv_nxt;
  logic [slp_pkg::VAL_W-1:0]  hum_r, hum_nxt;
  logic [slp_pkg::VAL_W-1:0]  temp_r, temp_nxt;

  assign pop = !q_status.empty && (!valid_r || out_ready);

  always_comb begin
    valid_nxt     = valid_r && !out_ready;
    seen_nxt      = seen_r;
    held_hum_nxt  = held_hum_r;
    held_temp_nxt = held_temp_r;
    ok_nxt        = ok_r;
    hv_nxt        = hv_r;
    hum_nxt       = hum_r;
    temp_nxt      = temp_r;
    if (pop) begin
      valid_nxt = 1'b1;
      ok_nxt    = q_data.ok;
      hv_nxt    = q_data.ok || seen_r;
      if (q_data.ok) begin
        seen_nxt      = 1'b1;
        held_hum_nxt  = q_data.hum;
        held_temp_nxt = q_data.temp;
        hum_nxt       = q_data.hum;
        temp_nxt      = q_data.temp;
      end else begin
        hum_nxt  = held_hum_r;
        temp_nxt = held_temp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    ok_r   <= ok_nxt;
    hv_r   <= hv_nxt;
    hum_r  <= hum_nxt;
    temp_r <= temp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      seen_r      <= 1'b0;
      held_hum_r  <= '0;
      held_temp_r <= '0;
    end else begin
      valid_r     <= valid_nxt;
      seen_r      <= seen_nxt;
      held_hum_r  <= held_hum_nxt;
      held_temp_r <= held_temp_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_line_ok     = ok_r;
  assign out_have_valid  = hv_r;
  assign out_humidity    = hum_r;
  assign out_temperature = temp_r;

endmodule

`default_nettype wire

>>> hw/rtl/sensor_line_parser_top.sv
// Sensor line parser: takes a byte stream of lines "humi:<int>temp:<int>" ended by LF.
// Input channel: in_valid/in_ready carry one byte (in_rx_byte) per transaction.
// Output channel: out_valid/out_ready carry one result per LF: out_line_ok,
// out_have_valid and the latest good out_humidity/out_temperature (signed 16-bit).
// Throughput: one byte per cycle while in_ready is high (low when the queue is full).
// Result path: the queue is written on the LF transaction; the back then loads its
// output register from the queue when out_valid is low or out_ready is high.
// Bytes other than LF produce no result. Lines longer than MAX_LINE bytes are
// dropped and parsing restarts with the next byte.
// Stall: when out_ready is low the output register and queue fill; in_ready drops
// only when the queue is full, so non-LF traffic keeps flowing until then.
// Reset (rst_n low, synchronous): parser returns to the start of a line, queue
// empties, out_valid drops, held values clear to zero; the output data is not reset.
`default_nettype none

module sensor_line_parser_top #(
  parameter int unsigned MAX_LINE = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        in_rx_byte,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_line_ok,
  output logic                                   out_have_valid,
  output logic signed [slp_pkg::VAL_W-1:0]       out_humidity,
  output logic signed [slp_pkg::VAL_W-1:0]       out_temperature
);

  slp_pkg::line_res_t push_data;
  slp_pkg::line_res_t pop_data;
  slp_pkg::q_status_t q_status;
  logic               push;
  logic               pop;
  logic               byte_take;

  assign in_ready  = !q_status.full;
  assign byte_take = in_valid && in_ready;

  slp_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .rx_byte   (in_rx_byte),
    .push      (push),
    .push_data (push_data)
  );

  slp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  slp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .q_data          (pop_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_line_ok     (out_line_ok),
    .out_have_valid  (out_have_valid),
    .out_humidity    (out_humidity),
    .out_temperature (out_temperature)
  );

endmodule

`default_nettype wire

>>> hw/rtl/slp_checker.sv
`default_nettype none

module slp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_line_ok,
  input wire logic        out_have_valid,
  input wire logic [15:0] out_humidity,
  input wire logic [15:0] out_temperature
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_humidity) &&
      $stable(out_temperature) && $stable(out_line_ok))
    else $error("result changed while stalled");

  a_ok_implies_have: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_ok |-> out_have_valid)
    else $error("good line without have_valid");

  a_zero_before_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_have_valid |-> out_humidity == 16'h0000 && out_temperature == 16'h0000)
    else $error("nonzero values before any good line");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sensor_line_parser_top slp_checker u_slp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_line_ok     (out_line_ok),
  .out_have_valid  (out_have_valid),
  .out_humidity    (out_humidity),
  .out_temperature (out_temperature)
);

`default_nettype wire

>>> tb/sensor_line_parser_top_tb.sv
`timescale 1ns / 100ps

module sensor_line_parser_top_tb;

  localparam int LINE_MAX   = 64;
  localparam int RAND_BYTES = 1260;

  typedef struct packed {
    logic                      ok;
    logic                      seen;
    logic [slp_pkg::VAL_W-1:0] hum;
    logic [slp_pkg::VAL_W-1:0] temp;
  } reading_t;

  logic                             clk;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [7:0]                       in_rx_byte = 8'h00;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             out_line_ok;
  logic                             out_have_valid;
  logic signed [slp_pkg::VAL_W-1:0] out_humidity;
  logic signed [slp_pkg::VAL_W-1:0] out_temperature;

  sensor_line_parser_top #(.MAX_LINE(LINE_MAX)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_line_ok     (out_line_ok),
    .out_have_valid  (out_have_valid),
    .out_humidity    (out_humidity),
    .out_temperature (out_temperature)
  );

  logic [7:0] tx_bytes [$];
  logic [7:0] line_txt [$];
  reading_t   reading_q [$];

  int err_cnt       = 0;
  int bytes_sent    = 0;
  int lines_ok      = 0;
  int lines_bad     = 0;
  int overlong_drop = 0;

  // parser mirror
  slp_pkg::stage_t           parse_st  = slp_pkg::ST_LIT1;
  logic [slp_pkg::IDX_W-1:0] tag_pos   = '0;
  logic                      neg       = 1'b0;
  logic [slp_pkg::VAL_W-1:0] acc       = '0;
  logic [slp_pkg::VAL_W-1:0] first_val = '0;
  logic [slp_pkg::LEN_W-1:0] line_len  = '0;
  logic [slp_pkg::VAL_W-1:0] held_hum  = '0;
  logic [slp_pkg::VAL_W-1:0] held_temp = '0;
  logic                      seen      = 1'b0;

  task automatic put_tx(input logic [7:0] b);
    tx_bytes.insert(tx_bytes.size(), b);
  endtask

  task automatic put_txt(input logic [7:0] b);
    line_txt.insert(line_txt.size(), b);
  endtask

  function automatic logic blank_char(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] tag_char(input logic second,
                                          input logic [slp_pkg::IDX_W-1:0] idx);
    string s;
    s = second ? "temp:" : "humi:";
    return s[idx];
  endfunction

  function automatic logic [slp_pkg::VAL_W-1:0] acc_digit(
      input logic [slp_pkg::VAL_W-1:0] a, input logic [7:0] c);
    int v;
    v = int'(a) * 10 + int'(c) - int'(slp_pkg::CH_ZERO);
    if (v > 32768) v = 32768;
    return v[slp_pkg::VAL_W-1:0];
  endfunction

  function automatic logic [slp_pkg::VAL_W-1:0] signed_value(
      input logic n, input logic [slp_pkg::VAL_W-1:0] a);
    int m;
    m = int'(a);
    if (n) begin
      if (m > 32768) m = 32768;
      m = -m;
    end else if (m > 32767) begin
      m = 32767;
    end
    return m[slp_pkg::VAL_W-1:0];
  endfunction

  task automatic clear_line();
    parse_st  = slp_pkg::ST_LIT1;
    tag_pos   = '0;
    neg       = 1'b0;
    acc       = '0;
    first_val = '0;
    line_len  = '0;
  endtask

  task automatic take_tag(input logic second, input logic [7:0] c,
                          input slp_pkg::stage_t nxt);
    if (tag_pos < slp_pkg::LIT_LEN && c == tag_char(second, tag_pos)) begin
      tag_pos++;
      if (tag_pos == slp_pkg::LIT_LEN) begin
        tag_pos  = '0;
        parse_st = nxt;
      end
    end else begin
      parse_st = slp_pkg::ST_FAIL;
    end
  endtask

  task automatic number_begin(input logic [7:0] c, input slp_pkg::stage_t sgn_st,
                              input slp_pkg::stage_t dig_st);
    if (!blank_char(c)) begin
      neg = 1'b0;
      acc = '0;
      if (c == slp_pkg::CH_PLUS || c == slp_pkg::CH_MINUS) begin
        neg      = (c == slp_pkg::CH_MINUS);
        parse_st = sgn_st;
      end else if (digit_char(c)) begin
        acc      = acc_digit(acc, c);
        parse_st = dig_st;
      end else begin
        parse_st = slp_pkg::ST_FAIL;
      end
    end
  endtask

  task automatic advance_parse(input logic [7:0] c);
    case (parse_st)
      slp_pkg::ST_LIT1: take_tag(1'b0, c, slp_pkg::ST_WS1);
      slp_pkg::ST_WS1:  number_begin(c, slp_pkg::ST_SGN1, slp_pkg::ST_DIG1);
      slp_pkg::ST_SGN1, slp_pkg::ST_SGN2: begin
        if (digit_char(c)) begin
          acc      = acc_digit(acc, c);
          parse_st = (parse_st == slp_pkg::ST_SGN1) ? slp_pkg::ST_DIG1 : slp_pkg::ST_DIG2;
        end else begin
          parse_st = slp_pkg::ST_FAIL;
        end
      end
      slp_pkg::ST_DIG1: begin
        if (digit_char(c)) begin
          acc = acc_digit(acc, c);
        end else begin
          first_val = signed_value(neg, acc);
          tag_pos   = '0;
          parse_st  = slp_pkg::ST_LIT2;
          take_tag(1'b1, c, slp_pkg::ST_WS2);
        end
      end
      slp_pkg::ST_LIT2: take_tag(1'b1, c, slp_pkg::ST_WS2);
      slp_pkg::ST_WS2:  number_begin(c, slp_pkg::ST_SGN2, slp_pkg::ST_DIG2);
      slp_pkg::ST_DIG2: begin
        if (digit_char(c)) acc = acc_digit(acc, c);
        else parse_st = slp_pkg::ST_DONE;
      end
      slp_pkg::ST_DONE: ;
      default: parse_st = slp_pkg::ST_FAIL;
    endcase
  endtask

  task automatic parse_rx_byte(input logic [7:0] c);
    reading_t r;
    if (c != slp_pkg::CH_LF) begin
      if (line_len >= LINE_MAX) begin
        clear_line();
        overlong_drop++;
      end else begin
        line_len++;
        advance_parse(c);
      end
    end else begin
      r.ok = 1'b0;
      if (parse_st == slp_pkg::ST_DIG2 || parse_st == slp_pkg::ST_DONE) begin
        held_hum  = first_val;
        held_temp = signed_value(neg, acc);
        seen      = 1'b1;
        r.ok      = 1'b1;
      end
      clear_line();
      r.seen = seen;
      r.hum  = held_hum;
      r.temp = held_temp;
      if (r.ok) lines_ok++;
      else lines_bad++;
      reading_q.insert(reading_q.size(), r);
    end
  endtask

  // stimulus builders
  function automatic logic [7:0] rand_non_lf();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == slp_pkg::CH_LF);
    return b;
  endfunction

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) put_tx(s[i]);
  endtask

  task automatic txt_str(input string s);
    for (int i = 0; i < s.len(); i++) put_txt(s[i]);
  endtask

  task automatic txt_blank();
    logic [7:0] ws [5] = '{8'h09, 8'h0B, 8'h0C, slp_pkg::CH_CR, slp_pkg::CH_SPACE};
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) put_txt(ws[$urandom_range(0, 4)]);
  endtask

  task automatic txt_number();
    int bnd [6] = '{32766, 32767, 32768, 32769, 65536, 99999};
    int sgn;
    int mode;
    sgn  = $urandom_range(0, 2);
    mode = $urandom_range(0, 9);
    if (sgn == 1) put_txt(slp_pkg::CH_PLUS);
    if (sgn == 2) put_txt(slp_pkg::CH_MINUS);
    if (mode < 5) txt_str($sformatf("%0d", $urandom_range(0, 99)));
    else if (mode < 7) txt_str($sformatf("%0d", $urandom_range(0, 32767)));
    else if (mode == 7) txt_str($sformatf("%0d", bnd[$urandom_range(0, 5)]));
    else repeat ($urandom_range(6, 9))
      put_txt(8'(slp_pkg::CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic txt_good_line();
    txt_str("humi:");
    txt_blank();
    txt_number();
    txt_str("temp:");
    txt_blank();
    txt_number();
    case ($urandom_range(0, 3))
      1: put_txt(slp_pkg::CH_CR);
      2: repeat ($urandom_range(1, 3)) put_txt(rand_non_lf());
      default: ;
    endcase
  endtask

  task automatic post_line();
    foreach (line_txt[i]) put_tx(line_txt[i]);
    put_tx(slp_pkg::CH_LF);
    line_txt.delete();
  endtask

  task automatic queue_random_line();
    int kind;
    kind = $urandom_range(0, 99);
    line_txt.delete();
    if (kind < 8) begin
      repeat ($urandom_range(0, 24)) put_txt(rand_non_lf());
    end else if (kind < 12) begin
      // fill the line buffer to its limit; usually overflow it, then recover with a fresh line
      txt_good_line();
      while (line_txt.size() < LINE_MAX) put_txt(rand_non_lf());
      if ($urandom_range(0, 3) != 0) begin
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1)
          put_txt(rand_non_lf());
        txt_good_line();
      end
    end else begin
      txt_good_line();
      if ($urandom_range(0, 6) == 0)
        line_txt[$urandom_range(0, line_txt.size() - 1)] = rand_non_lf();
    end
    post_line();
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver: bursts with random gaps
  int  burst_left = 0;
  int  gap_left   = 0;
  bit  in_taken   = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold until the transaction completes
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (tx_bytes.size() != 0) begin
      in_valid   <= 1'b1;
      in_rx_byte <= tx_bytes.pop_front();
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24);
        gap_left   = $urandom_range(0, 5);
      end else begin
        burst_left--;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall pattern
  int stall_mode = 0;
  int stall_cyc  = 0;
  int stall_hold = 0;
  int rx_cyc     = 0;

  always @(negedge clk) begin : rx_pattern
    logic rdy;
    if (stall_cyc == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cyc  = 300;
    end
    stall_cyc--;
    rx_cyc++;
    case (stall_mode)
      0: rdy = 1'b1;
      1: rdy = (rx_cyc % 4) != 3;
      2: rdy = 1'($urandom_range(0, 1));
      default: begin
        if (stall_hold > 0) begin
          stall_hold--;
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
          if ($urandom_range(0, 9) == 0) stall_hold = $urandom_range(5, 25);
        end
      end
    endcase
    out_ready <= rdy;
  end

  // monitor
  always @(posedge clk) begin : monitor
    reading_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (reading_q.size() == 0) begin
          $error("unexpected result transaction: line_ok=%0b hum=%0d temp=%0d",
                 out_line_ok, out_humidity, out_temperature);
          err_cnt++;
        end else begin
          want = reading_q.pop_front();
          if (out_line_ok !== want.ok) begin
            $error("line_ok: expected %0b, got %0b", want.ok, out_line_ok);
            err_cnt++;
          end
          if (out_have_valid !== want.seen) begin
            $error("have_valid: expected %0b, got %0b", want.seen, out_have_valid);
            err_cnt++;
          end
          if (out_humidity !== want.hum) begin
            $error("humidity: expected %0d, got %0d", $signed(want.hum), out_humidity);
            err_cnt++;
          end
          if (out_temperature !== want.temp) begin
            $error("temperature: expected %0d, got %0d", $signed(want.temp),
                   out_temperature);
            err_cnt++;
          end
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        bytes_sent++;
        parse_rx_byte(in_rx_byte);
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  initial begin
    int base;
    // directed lines
    put_tx(slp_pkg::CH_LF);
    send_str("humi:temp:1\n");
    send_str("humi:0temp:0\n");
    send_str("humi:32767temp:-32768\n");
    send_str("humi:-99999temp:32768\n");
    send_str("humi:");
    put_tx(8'h09);
    put_tx(slp_pkg::CH_SPACE);
    put_tx(slp_pkg::CH_CR);
    send_str("+12temp:");
    put_tx(8'h0B);
    put_tx(8'h0C);
    send_str("-007");
    put_tx(slp_pkg::CH_CR);
    put_tx(slp_pkg::CH_LF);
    send_str("humi:5temp:6xyz");
    put_tx(8'hFF);
    put_tx(8'h80);
    put_tx(slp_pkg::CH_LF);
    send_str("Humi:1temp:2\n");
    send_str("humi:-temp:1\n");
    send_str("humi:1");
    put_tx(8'h00);
    send_str("temp:2\n");
    send_str("humi:4");
    put_tx(8'hFF);
    send_str("temp:2\n");
    send_str("humi:1 temp:2\n");
    send_str("humi:+0temp:-0\n");
    // exactly full buffer, still good
    send_str("humi:1temp:2");
    repeat (LINE_MAX - 12) put_tx(slp_pkg::CH_SPACE);
    put_tx(slp_pkg::CH_LF);
    // one byte past full: dropped, parse restarts
    send_str("humi:9temp:9");
    repeat (LINE_MAX - 12) send_str("x");
    send_str("Zhumi:3temp:-4\n");

    base = tx_bytes.size();
    while (tx_bytes.size() - base < RAND_BYTES) queue_random_line();

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (tx_bytes.size() != 0 || in_valid) @(posedge clk);
    while (reading_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d bytes over %0d lines: %0d parsed, %0d rejected",
             bytes_sent, lines_ok + lines_bad, lines_ok, lines_bad);
    $display("buffer overflows: %0d, mismatches: %0d", overlong_drop, err_cnt);
    if (err_cnt == 0) begin
      $display("sensor_line_parser_top_tb: done, clean");
    end else begin
      $display("sensor_line_parser_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout waiting for transactions");
    $display("sensor_line_parser_top_tb: done, errors");
    $finish;
  end

endmodule
